[rtl/vbb9_pkg.sv]
// Shared types and constants for the vertical 9-tap box blur.
package vbb9_pkg;

  localparam int PIX_W       = 8;
  localparam int COORD_W     = 10;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int TAPS_STORED = 8;
  localparam int LINE_W      = TAPS_STORED * PIX_W;
  localparam int HALF_TAPS   = 4;
  localparam int SUM_W       = 12;

  // Divide by nine as a multiply by ceil(2^16 / 9) and a shift; exact for sums up to 9 * 255.
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP9 = 13'd7282;
  localparam int RECIP_SHIFT = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_out;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_column;
    logic               last;
  } pix_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     wdata;
  } cfg_word_t;

  typedef struct packed {
    logic emit_delayed;
    logic delayed_pass;
    logic emit_own;
  } row_flags_t;

endpackage

[rtl/vbb9_chan_if.sv]
// Valid/ready channel interface carrying one word of a given type.
interface vbb9_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/vbb9_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module vbb9_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/vbb9_pos.sv]
// Frame size registers and raster position counters for incoming pixels.
module vbb9_pos #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  vbb9_pkg::cfg_word_t               cfg_i,
  input  logic                              adv_i,
  input  logic                              frame_start_i,
  output logic [$clog2(MAX_WIDTH)-1:0]      col_o,
  output logic [$clog2(MAX_HEIGHT)-1:0]     row_o,
  output vbb9_pkg::row_flags_t              flags_o,
  output logic [$clog2(MAX_HEIGHT+1)+vbb9_pkg::CFG_W-1:0] eff_h_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = ($clog2(MAX_WIDTH + 1) > vbb9_pkg::CFG_W) ?
                       $clog2(MAX_WIDTH + 1) : vbb9_pkg::CFG_W;
  localparam int HW  = ($clog2(MAX_HEIGHT + 1) > vbb9_pkg::CFG_W) ?
                       $clog2(MAX_HEIGHT + 1) : vbb9_pkg::CFG_W;
  localparam int XCW = (WW > CW + 1) ? WW : CW + 1;
  localparam int XRW = (HW > RW + 1) ? HW : RW + 1;
  localparam int EHW = $clog2(MAX_HEIGHT + 1) + vbb9_pkg::CFG_W;
  localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int RST_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  logic [WW-1:0] width_q;
  logic [HW-1:0] height_q;
  logic [WW-1:0] cfg_w;
  logic [HW-1:0] cfg_h;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW:0]   c0, cn;
  logic [RW:0]   r0, r1, rn;
  logic [CW-1:0] c1;
  logic [RW-1:0] r;

  always_comb begin
    cfg_w = WW'(cfg_i.wdata);
    cfg_h = HW'(cfg_i.wdata);
    if (cfg_w == '0) begin
      cfg_w = WW'(1);
    end else if (cfg_w > WW'(MAX_WIDTH)) begin
      cfg_w = WW'(MAX_WIDTH);
    end
    if (cfg_h == '0) begin
      cfg_h = HW'(1);
    end else if (cfg_h > HW'(MAX_HEIGHT)) begin
      cfg_h = HW'(MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(RST_W);
      height_q <= HW'(RST_H);
    end else if (cfg_we_i) begin
      unique case (cfg_i.reg_index)
        vbb9_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_w;
        vbb9_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_h;
      endcase
    end
  end

  // A counter left at or past a limit that was just lowered wraps before the pixel is placed.
  always_comb begin
    c0 = frame_start_i ? '0 : {1'b0, col_q};
    r0 = frame_start_i ? '0 : {1'b0, row_q};
    if (XCW'(c0) >= XCW'(width_q)) begin
      c1 = '0;
      r1 = r0 + (RW+1)'(1);
    end else begin
      c1 = c0[CW-1:0];
      r1 = r0;
    end
    r = (XRW'(r1) >= XRW'(height_q)) ? '0 : r1[RW-1:0];

    cn    = {1'b0, c1} + (CW+1)'(1);
    rn    = {1'b0, r} + (RW+1)'(1);
    col_d = cn[CW-1:0];
    row_d = r;
    if (XCW'(cn) >= XCW'(width_q)) begin
      col_d = '0;
      row_d = (XRW'(rn) >= XRW'(height_q)) ? '0 : rn[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (adv_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o = c1;
  assign row_o = r;
  assign flags_o.emit_delayed = (r >= RW'(vbb9_pkg::HALF_TAPS));
  assign flags_o.delayed_pass = (r < RW'(2 * vbb9_pkg::HALF_TAPS));
  assign flags_o.emit_own     = (XRW'({1'b0, r}) + XRW'(vbb9_pkg::HALF_TAPS)) >=
                                XRW'(height_q);
  assign eff_h_o = EHW'(height_q);

endmodule

[rtl/vbb9_avg.sv]
// Column average over nine rows and formation of the one or two result words.
module vbb9_avg #(
  parameter int MAX_HEIGHT = 1024
) (
  input  logic [vbb9_pkg::LINE_W-1:0]   stored_i,
  input  logic [vbb9_pkg::PIX_W-1:0]    pix_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0] row_i,
  input  logic [vbb9_pkg::COORD_W-1:0]  col_i,
  input  vbb9_pkg::row_flags_t          flags_i,
  output logic                          has_a_o,
  output logic                          has_b_o,
  output vbb9_pkg::pix_out_t            res_a_o,
  output vbb9_pkg::pix_out_t            res_b_o
);

  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int PROD_W = vbb9_pkg::SUM_W + vbb9_pkg::RECIP_W;

  logic [vbb9_pkg::SUM_W-1:0] sum;
  logic [PROD_W-1:0]          prod;
  logic [vbb9_pkg::PIX_W-1:0] mean;
  logic [vbb9_pkg::PIX_W-1:0] delayed_pix;
  logic [RW-1:0]              k;

  always_comb begin
    sum = vbb9_pkg::SUM_W'(pix_i);
    for (int j = 0; j < vbb9_pkg::TAPS_STORED; j++) begin
      sum = sum + vbb9_pkg::SUM_W'(stored_i[j*vbb9_pkg::PIX_W +: vbb9_pkg::PIX_W]);
    end
  end

  assign prod = PROD_W'(sum) * PROD_W'(vbb9_pkg::RECIP9);
  assign mean = prod[vbb9_pkg::RECIP_SHIFT +: vbb9_pkg::PIX_W];

  // The top rows come back unfiltered from the line store entry of the row four above.
  assign delayed_pix = flags_i.delayed_pass ?
                       stored_i[(vbb9_pkg::HALF_TAPS-1)*vbb9_pkg::PIX_W +: vbb9_pkg::PIX_W] :
                       mean;
  assign k = row_i - RW'(vbb9_pkg::HALF_TAPS);

  assign has_a_o = flags_i.emit_delayed;
  assign has_b_o = flags_i.emit_own;

  assign res_a_o.pixel_out  = delayed_pix;
  assign res_a_o.out_row    = vbb9_pkg::COORD_W'(k);
  assign res_a_o.out_column = col_i;
  assign res_a_o.last       = !flags_i.emit_own;

  assign res_b_o.pixel_out  = pix_i;
  assign res_b_o.out_row    = vbb9_pkg::COORD_W'(row_i);
  assign res_b_o.out_column = col_i;
  assign res_b_o.last       = 1'b1;

endmodule

[rtl/vbb9_out_buf.sv]
// Two-entry output buffer that takes up to two result words at once and sends them in order.
module vbb9_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               has_a_i,
  input  logic               has_b_i,
  input  vbb9_pkg::pix_out_t res_a_i,
  input  vbb9_pkg::pix_out_t res_b_i,
  output logic               can_take_o,
  output logic               valid_o,
  input  logic               ready_i,
  output vbb9_pkg::pix_out_t data_o
);

  logic [1:0]         cnt_q, cnt_d;
  vbb9_pkg::pix_out_t slot0_q, slot0_d;
  vbb9_pkg::pix_out_t slot1_q, slot1_d;
  logic               pop;

  assign pop        = valid_o && ready_i;
  assign valid_o    = (cnt_q != 2'd0);
  assign data_o     = slot0_q;
  assign can_take_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (push_i) begin
      cnt_d   = 2'({1'b0, has_a_i} + {1'b0, has_b_i});
      slot0_d = has_a_i ? res_a_i : res_b_i;
      slot1_d = res_b_i;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

[rtl/vertical_box_blur_9tap.sv]
// Top level of the vertical 9-tap box blur for 8-bit grey images in raster order.
//
// Pixels arrive one word per cycle and the block sustains one pixel per clock while the
// result port is ready: each pixel reads its column's line store entry once when it is
// accepted into the line store stage and writes it back once as it leaves, through a
// single-port-per-direction RAM of MAX_WIDTH entries with a write-to-read bypass for narrow
// images. A pixel of rows four and up releases the row four above it (the nine-row mean, or
// the stored value for the top four rows); a pixel of the last four rows also releases
// itself, and such a pixel holds up the next because the result port carries one word per
// cycle. The two-entry output buffer takes both words of a pixel at once; while the result
// port stalls, one more pixel is taken into the line store stage and input then waits. The
// line store needs no clearing pass after reset.
module vertical_box_blur_9tap #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input logic        clk_i,
  input logic        rst_ni,
  vbb9_chan_if.sink   in_if,
  vbb9_chan_if.source out_if,
  vbb9_chan_if.sink   cfg_if
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int EHW = $clog2(MAX_HEIGHT + 1) + vbb9_pkg::CFG_W;

  vbb9_pkg::pix_in_t    in_word;
  vbb9_pkg::cfg_word_t  cfg_word;
  logic                 accept;
  logic                 s1_adv;
  logic                 can_take;

  logic [CW-1:0]        pos_col;
  logic [RW-1:0]        pos_row;
  vbb9_pkg::row_flags_t pos_flags;
  logic [EHW-1:0]       eff_h;

  logic                       s1_valid_q;
  logic [vbb9_pkg::PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]              s1_col_q;
  logic [RW-1:0]              s1_row_q;
  vbb9_pkg::row_flags_t       s1_flags_q;
  logic                        fwd_q;
  logic [vbb9_pkg::LINE_W-1:0] fwd_data_q;

  logic [vbb9_pkg::LINE_W-1:0] ram_rdata;
  logic [vbb9_pkg::LINE_W-1:0] stored;
  logic [vbb9_pkg::LINE_W-1:0] line_wdata;

  logic               has_a, has_b;
  vbb9_pkg::pix_out_t res_a, res_b;
  vbb9_pkg::pix_out_t out_word;

  assign in_word   = in_if.data;
  assign cfg_word  = cfg_if.data;
  assign cfg_if.ready = 1'b1;

  assign s1_adv      = s1_valid_q && can_take;
  assign in_if.ready = !s1_valid_q || s1_adv;
  assign accept      = in_if.valid && in_if.ready;

  vbb9_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_if.valid),
    .cfg_i         (cfg_word),
    .adv_i         (accept),
    .frame_start_i (in_word.frame_start),
    .col_o         (pos_col),
    .row_o         (pos_row),
    .flags_o       (pos_flags),
    .eff_h_o       (eff_h)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        // The entry written in this same cycle is not yet visible at the RAM read port.
        fwd_q      <= s1_adv && (s1_col_q == pos_col);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= in_word.pixel_in;
      s1_col_q   <= pos_col;
      s1_row_q   <= pos_row;
      s1_flags_q <= pos_flags;
      fwd_data_q <= line_wdata;
    end
  end

  assign stored     = fwd_q ? fwd_data_q : ram_rdata;
  assign line_wdata = {stored[vbb9_pkg::LINE_W-vbb9_pkg::PIX_W-1:0], s1_pix_q};

  vbb9_ram #(
    .WIDTH (vbb9_pkg::LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (line_wdata),
    .re_i    (accept),
    .raddr_i (pos_col),
    .rdata_o (ram_rdata)
  );

  vbb9_avg #(
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_avg (
    .stored_i (stored),
    .pix_i    (s1_pix_q),
    .row_i    (s1_row_q),
    .col_i    (vbb9_pkg::COORD_W'(s1_col_q)),
    .flags_i  (s1_flags_q),
    .has_a_o  (has_a),
    .has_b_o  (has_b),
    .res_a_o  (res_a),
    .res_b_o  (res_b)
  );

  vbb9_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s1_adv),
    .has_a_i    (has_a),
    .has_b_i    (has_b),
    .res_a_i    (res_a),
    .res_b_i    (res_b),
    .can_take_o (can_take),
    .valid_o    (out_if.valid),
    .ready_i    (out_if.ready),
    .data_o     (out_word)
  );

  assign out_if.data = out_word;

  a_fwd_only_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !(s1_adv && (s1_col_q == pos_col)) |=> !fwd_q)
    else $error("line store bypass selected without a same-column write");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (EHW'(s1_row_q) < eff_h))
    else $error("staged pixel row is outside the frame height");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_col_q) && $stable(s1_row_q))
    else $error("stalled pixel left the line store stage");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for vertical_box_blur_9tap against a line-store predictor.
module testbench;
  import vbb9_pkg::*;

  localparam int MAX_DIM       = 1024;
  localparam int BLUR_TAPS     = 2 * HALF_TAPS + 1;
  localparam int SETTLE_CYCLES = 8;

  class blur_scoreboard;
    logic [LINE_W-1:0] column_history [MAX_DIM];
    logic [CFG_W-1:0]  width_reg  = 11'd1024;
    logic [CFG_W-1:0]  height_reg = 11'd1024;
    int unsigned       col_pos;
    int unsigned       row_pos;
    pix_out_t          expected_pixels [$];
    int unsigned       failures;

    function int unsigned effective_size(logic [CFG_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > MAX_DIM) return MAX_DIM;
      return raw;
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    function string show(pix_out_t word);
      return $sformatf("pixel %0d row %0d column %0d last %0b",
                       word.pixel_out, word.out_row, word.out_column, word.last);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = value;
      end else if (idx == REG_IMAGE_HEIGHT) begin
        height_reg = value;
      end
    endfunction

    function void note_pixel(pix_in_t word);
      int unsigned w, h, r, c, sum, j;
      logic [LINE_W-1:0] hist;
      pix_out_t res;
      w = effective_size(width_reg);
      h = effective_size(height_reg);
      if (word.frame_start) begin
        col_pos = 0;
        row_pos = 0;
      end
      // A size change can leave the counters past the new limits.
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      c = col_pos;
      hist = column_history[c];
      if (r >= HALF_TAPS) begin
        sum = word.pixel_in;
        for (j = 0; j < TAPS_STORED; j++) sum += hist[PIX_W*j +: PIX_W];
        res.pixel_out  = (r - HALF_TAPS < HALF_TAPS) ? hist[PIX_W*(HALF_TAPS-1) +: PIX_W]
                                                     : PIX_W'(sum / BLUR_TAPS);
        res.out_row    = COORD_W'(r - HALF_TAPS);
        res.out_column = COORD_W'(c);
        res.last       = (r + HALF_TAPS < h);
        expected_pixels.push_back(res);
      end
      if (r + HALF_TAPS >= h) begin
        res.pixel_out  = word.pixel_in;
        res.out_row    = COORD_W'(r);
        res.out_column = COORD_W'(c);
        res.last       = 1'b1;
        expected_pixels.push_back(res);
      end
      column_history[c] = {hist[LINE_W-PIX_W-1:0], word.pixel_in};
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void check_pixel(pix_out_t got);
      pix_out_t want;
      if (expected_pixels.size() == 0) begin
        note_failure($sformatf("unexpected result %s", show(got)));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_out !== want.pixel_out || got.out_row !== want.out_row ||
          got.out_column !== want.out_column || got.last !== want.last) begin
        note_failure($sformatf("expected %s, got %s", show(want), show(got)));
      end
    endfunction

    function void close();
      if (expected_pixels.size() != 0) begin
        note_failure($sformatf("%0d results never arrived", expected_pixels.size()));
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   gaps_on;
  bit   stalls_on;
  blur_scoreboard board;

  vbb9_chan_if #(.T(pix_in_t))   pix_in_if ();
  vbb9_chan_if #(.T(pix_out_t))  pix_out_if ();
  vbb9_chan_if #(.T(cfg_word_t)) cfg_if ();

  vertical_box_blur_9tap uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (pix_in_if),
    .out_if (pix_out_if),
    .cfg_if (cfg_if)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        board.set_register(cfg_if.data.reg_index, cfg_if.data.wdata);
      end
      if (pix_in_if.valid && pix_in_if.ready) board.note_pixel(pix_in_if.data);
      if (pix_out_if.valid && pix_out_if.ready) board.check_pixel(pix_out_if.data);
    end
  end

  initial begin
    pix_out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        pix_out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      pix_out_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] value, input logic restart);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      pix_in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    pix_in_if.valid <= 1'b1;
    pix_in_if.data  <= '{pixel_in: value, frame_start: restart};
    @(posedge clk);
    while (!pix_in_if.ready) @(posedge clk);
  endtask

  // A noise of n restarts the frame on about one word in n; zero never does.
  task automatic send_run(input int unsigned count, input bit restart_first,
                          input int unsigned noise);
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(PIX_W'($urandom_range(0, 255)),
                 (i == 0 && restart_first) || (noise != 0 && $urandom_range(1, noise) == 1));
    end
    pix_in_if.valid <= 1'b0;
  endtask

  task automatic write_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{reg_index: REG_IMAGE_WIDTH, wdata: w};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.data <= '{reg_index: REG_IMAGE_HEIGHT, wdata: h};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned w, h;
    board = new();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    pix_in_if.valid <= 1'b0;
    pix_in_if.data  <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.data     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Column 0 holds full-scale pixels, column 1 uneven ones; then a counter
    // wrap and a restart.
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    write_size(11'd2, 11'd10);
    for (int i = 0; i < 20; i++) begin
      send_pixel((i % 2 == 0) ? 8'hFF : PIX_W'(37 * i + 5), i == 0);
    end
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h01, 1'b1);
    pix_in_if.valid <= 1'b0;
    settle();

    write_size(11'd0, 11'd0);
    send_run(40, 1'b1, 0);
    settle();
    write_size(11'd1, 11'd2047);
    send_run(1030, 1'b1, 0);
    settle();

    // Shrink the width mid-row, then the height below the current row.
    write_size(11'd8, 11'd30);
    send_run(100, 1'b1, 0);
    settle();
    write_size(11'd3, 11'd30);
    send_run(60, 1'b0, 0);
    settle();
    write_size(11'd3, 11'd2);
    send_run(12, 1'b0, 0);
    settle();

    repeat (6) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      w = $urandom_range(1, 8);
      h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 24);
      write_size(CFG_W'(w), CFG_W'(h));
      send_run($urandom_range(30, 50), 1'b1, 400);
      settle();
    end

    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_size(11'd5, 11'd12);
    send_run(60, 1'b1, 400);
    settle();

    board.close();
    if (board.failures == 0) begin
      $display("PASS vertical_box_blur_9tap");
    end else begin
      $display("FAIL vertical_box_blur_9tap");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL vertical_box_blur_9tap");
    $finish;
  end

endmodule

[files.f]
rtl/vbb9_pkg.sv
rtl/vbb9_chan_if.sv
rtl/vbb9_ram.sv
rtl/vbb9_pos.sv
rtl/vbb9_avg.sv
rtl/vbb9_out_buf.sv
rtl/vertical_box_blur_9tap.sv
dv/testbench.sv
